>>> sv/ks_pkg.sv
// ----------------------------------------------------------------------------
// ks_pkg
// Shared widths, types and constants of the regularization pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package ks_pkg;

  localparam int DATA_W    = 64;
  localparam int FRAC_BITS = 32;
  // Divider numerator: a 64-bit magnitude scaled by 2^(FRAC_BITS-1).
  localparam int NUM_W     = DATA_W + FRAC_BITS - 1;
  // Square root radicand and root.
  localparam int RAD_W     = 2 * DATA_W;
  localparam int ROOT_W    = DATA_W;
  localparam int REM_W     = DATA_W + 4;
  // Exact momentum sum before rescaling.
  localparam int SUM_W     = 2 * DATA_W + 2;

  localparam logic [DATA_W-1:0] SMAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] SMIN = {1'b1, {(DATA_W-1){1'b0}}};

  // Which coordinate component multiplies mx, my, mz in each momentum output.
  localparam logic [1:0] QSEL [4][3] = '{
    '{2'd0, 2'd1, 2'd2},
    '{2'd1, 2'd0, 2'd3},
    '{2'd2, 2'd3, 2'd0},
    '{2'd3, 2'd2, 2'd1}
  };
  // Terms that enter their sum negated.
  localparam logic MINUS [4][3] = '{
    '{1'b0, 1'b0, 1'b0},
    '{1'b1, 1'b0, 1'b0},
    '{1'b1, 1'b1, 1'b0},
    '{1'b0, 1'b1, 1'b0}
  };

  // Data that rides along the long arithmetic units.
  typedef struct packed {
    logic              deg;
    logic              xneg;
    logic [DATA_W-1:0] adx;
    logic [DATA_W-1:0] dy;
    logic [DATA_W-1:0] dz;
    logic [DATA_W-1:0] mx;
    logic [DATA_W-1:0] my;
    logic [DATA_W-1:0] mz;
    logic [DATA_W-1:0] s;
  } side_t;

endpackage

`default_nettype wire

>>> sv/ks_if.sv
// ----------------------------------------------------------------------------
// ks_req_if / ks_res_if
// Valid/ready channels for the input pair and the regularized result.
// ----------------------------------------------------------------------------
`default_nettype none

interface ks_req_if;
  import ks_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] body_x;
  logic signed [DATA_W-1:0] body_y;
  logic signed [DATA_W-1:0] body_z;
  logic signed [DATA_W-1:0] ref_x;
  logic signed [DATA_W-1:0] ref_y;
  logic signed [DATA_W-1:0] ref_z;
  logic signed [DATA_W-1:0] mom_x;
  logic signed [DATA_W-1:0] mom_y;
  logic signed [DATA_W-1:0] mom_z;
  modport source (output valid, body_x, body_y, body_z, ref_x, ref_y, ref_z,
                  mom_x, mom_y, mom_z, input ready);
  modport sink   (input valid, body_x, body_y, body_z, ref_x, ref_y, ref_z,
                  mom_x, mom_y, mom_z, output ready);
endinterface

interface ks_res_if;
  import ks_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] ks_q1;
  logic signed [DATA_W-1:0] ks_q2;
  logic signed [DATA_W-1:0] ks_q3;
  logic signed [DATA_W-1:0] ks_q4;
  logic signed [DATA_W-1:0] ks_p1;
  logic signed [DATA_W-1:0] ks_p2;
  logic signed [DATA_W-1:0] ks_p3;
  logic signed [DATA_W-1:0] ks_p4;
  logic                     degenerate;
  modport source (output valid, ks_q1, ks_q2, ks_q3, ks_q4, ks_p1, ks_p2, ks_p3,
                  ks_p4, degenerate, input ready);
  modport sink   (input valid, ks_q1, ks_q2, ks_q3, ks_q4, ks_p1, ks_p2, ks_p3,
                  ks_p4, degenerate, output ready);
endinterface

`default_nettype wire

>>> sv/ks_isqrt.sv
// ----------------------------------------------------------------------------
// ks_isqrt
// Pipelined integer square root, one root bit per stage, floor result.
// ----------------------------------------------------------------------------
`default_nettype none

module ks_isqrt (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      en_i,
  input  wire logic                      vld_i,
  input  wire ks_pkg::side_t             side_i,
  input  wire logic [ks_pkg::RAD_W-1:0]  rad_i,
  output logic                           vld_o,
  output ks_pkg::side_t                  side_o,
  output logic [ks_pkg::ROOT_W-1:0]      root_o
);
  import ks_pkg::*;

  logic [RAD_W-1:0]  n_q    [ROOT_W];
  logic [REM_W-1:0]  rem_q  [ROOT_W];
  logic [ROOT_W-1:0] root_q [ROOT_W];
  side_t             side_q [ROOT_W];
  logic [ROOT_W-1:0] vld_q;

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    logic [RAD_W-1:0]  n_p;
    logic [REM_W-1:0]  rem_p;
    logic [ROOT_W-1:0] root_p;
    side_t             side_p;
    logic              vld_p;
    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic              take;

    if (k == 0) begin : g_first
      assign n_p    = rad_i;
      assign rem_p  = '0;
      assign root_p = '0;
      assign side_p = side_i;
      assign vld_p  = vld_i;
    end else begin : g_next
      assign n_p    = n_q[k-1];
      assign rem_p  = rem_q[k-1];
      assign root_p = root_q[k-1];
      assign side_p = side_q[k-1];
      assign vld_p  = vld_q[k-1];
    end

    // Bring down the next two radicand bits and try root*4+1.
    assign rem_sh = {rem_p[REM_W-3:0], n_p[RAD_W-1 -: 2]};
    assign trial  = REM_W'({root_p, 2'b01});
    assign take   = (rem_sh >= trial);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        n_q[k]    <= n_p << 2;
        rem_q[k]  <= take ? (rem_sh - trial) : rem_sh;
        root_q[k] <= {root_p[ROOT_W-2:0], take};
        side_q[k] <= side_p;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_p;
      end
    end
  end

  assign vld_o  = vld_q[ROOT_W-1];
  assign side_o = side_q[ROOT_W-1];
  assign root_o = root_q[ROOT_W-1];

endmodule

`default_nettype wire

>>> sv/ks_div.sv
// ----------------------------------------------------------------------------
// ks_div
// Pipelined restoring divider, two numerators over one shared divisor,
// one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module ks_div (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      en_i,
  input  wire logic                      vld_i,
  input  wire ks_pkg::side_t             side_i,
  input  wire logic [ks_pkg::NUM_W-1:0]  num_y_i,
  input  wire logic [ks_pkg::NUM_W-1:0]  num_z_i,
  input  wire logic [ks_pkg::DATA_W-1:0] den_i,
  output logic                           vld_o,
  output ks_pkg::side_t                  side_o,
  output logic [ks_pkg::NUM_W-1:0]       quo_y_o,
  output logic [ks_pkg::NUM_W-1:0]       quo_z_o
);
  import ks_pkg::*;

  logic [NUM_W-1:0]  ny_q [NUM_W];
  logic [NUM_W-1:0]  nz_q [NUM_W];
  logic [DATA_W-1:0] ry_q [NUM_W];
  logic [DATA_W-1:0] rz_q [NUM_W];
  logic [NUM_W-1:0]  qy_q [NUM_W];
  logic [NUM_W-1:0]  qz_q [NUM_W];
  logic [DATA_W-1:0] den_q [NUM_W];
  side_t             side_q [NUM_W];
  logic [NUM_W-1:0]  vld_q;

  for (genvar k = 0; k < NUM_W; k++) begin : g_stage
    logic [NUM_W-1:0]  ny_p, nz_p, qy_p, qz_p;
    logic [DATA_W-1:0] ry_p, rz_p, den_p;
    side_t             side_p;
    logic              vld_p;
    logic [DATA_W:0]   shy, shz;
    logic              tky, tkz;

    if (k == 0) begin : g_first
      assign ny_p   = num_y_i;
      assign nz_p   = num_z_i;
      assign ry_p   = '0;
      assign rz_p   = '0;
      assign qy_p   = '0;
      assign qz_p   = '0;
      assign den_p  = den_i;
      assign side_p = side_i;
      assign vld_p  = vld_i;
    end else begin : g_next
      assign ny_p   = ny_q[k-1];
      assign nz_p   = nz_q[k-1];
      assign ry_p   = ry_q[k-1];
      assign rz_p   = rz_q[k-1];
      assign qy_p   = qy_q[k-1];
      assign qz_p   = qz_q[k-1];
      assign den_p  = den_q[k-1];
      assign side_p = side_q[k-1];
      assign vld_p  = vld_q[k-1];
    end

    assign shy = {ry_p, ny_p[NUM_W-1]};
    assign shz = {rz_p, nz_p[NUM_W-1]};
    assign tky = (shy >= {1'b0, den_p});
    assign tkz = (shz >= {1'b0, den_p});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        ny_q[k]   <= ny_p << 1;
        nz_q[k]   <= nz_p << 1;
        ry_q[k]   <= tky ? DATA_W'(shy - {1'b0, den_p}) : shy[DATA_W-1:0];
        rz_q[k]   <= tkz ? DATA_W'(shz - {1'b0, den_p}) : shz[DATA_W-1:0];
        qy_q[k]   <= {qy_p[NUM_W-2:0], tky};
        qz_q[k]   <= {qz_p[NUM_W-2:0], tkz};
        den_q[k]  <= den_p;
        side_q[k] <= side_p;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_p;
      end
    end
  end

  assign vld_o   = vld_q[NUM_W-1];
  assign side_o  = side_q[NUM_W-1];
  assign quo_y_o = qy_q[NUM_W-1];
  assign quo_z_o = qz_q[NUM_W-1];

endmodule

`default_nettype wire

>>> sv/ks_regularize_pair.sv
// ----------------------------------------------------------------------------
// ks_regularize_pair
// Kustaanheimo-Stiefel regularization of one body against a reference body.
// ----------------------------------------------------------------------------
// The block takes one request per cycle while its result output is not
// stalled. Most of the pipeline depth is in the two bit-per-stage square
// roots and the bit-per-stage divider that forms both scaled coordinates.
// The whole pipeline advances together: it holds while a finished result
// waits at the output, and request ready follows that. A zero relative
// distance returns all-zero fields with degenerate set.
`default_nettype none

module ks_regularize_pair (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  ks_req_if.sink     req_i,
  ks_res_if.source   res_o
);
  import ks_pkg::*;

  function automatic logic [DATA_W-1:0] sat_sub(logic [DATA_W-1:0] a,
                                                logic [DATA_W-1:0] b);
    logic [DATA_W-1:0] d;
    logic              ovf;
    d   = a - b;
    ovf = (a[DATA_W-1] ^ b[DATA_W-1]) & (a[DATA_W-1] ^ d[DATA_W-1]);
    if (ovf) return a[DATA_W-1] ? SMIN : SMAX;
    return d;
  endfunction

  function automatic logic [DATA_W-1:0] mag(logic [DATA_W-1:0] v);
    return v[DATA_W-1] ? (~v + 1'b1) : v;
  endfunction

  function automatic logic [DATA_W-1:0] sat_sm(logic neg, logic [NUM_W-1:0] m);
    logic big_pos, big_neg;
    big_pos = |m[NUM_W-1:DATA_W-1];
    big_neg = (|m[NUM_W-1:DATA_W]) | (m[DATA_W-1] & (|m[DATA_W-2:0]));
    if (!neg) return big_pos ? SMAX : m[DATA_W-1:0];
    return big_neg ? SMIN : (~m[DATA_W-1:0] + 1'b1);
  endfunction

  logic en;

  // Stage 0: request register.
  logic              v0_q;
  logic [DATA_W-1:0] bx0_q, by0_q, bz0_q, rx0_q, ry0_q, rz0_q, mx0_q, my0_q, mz0_q;

  // Stage 1: relative position.
  logic              v1_q;
  side_t             sd1_q;
  logic [DATA_W-1:0] ay1_q, az1_q;
  logic [DATA_W-1:0] dx, dy, dz;

  // Stage 2: partial products of the three squares.
  logic              v2_q;
  side_t             sd2_q;
  logic [DATA_W-1:0] hh2_q [3];
  logic [DATA_W-1:0] hl2_q [3];
  logic [DATA_W-1:0] ll2_q [3];

  // Stage 3 and 4: squares, then their sum.
  logic              v3_q, v4_q;
  side_t             sd3_q, sd4_q;
  logic [RAD_W-1:0]  sq3_q [3];
  logic [RAD_W-1:0]  sum4_q;

  // Distance root.
  logic              va_vld;
  side_t             sda;
  logic [ROOT_W-1:0] r_root;

  // Stage 5: radicand of the main component.
  logic              v5_q;
  side_t             sd5_q;
  logic [RAD_W-1:0]  n5_q;

  // Main component root.
  logic              vb_vld;
  side_t             sdb;
  logic [ROOT_W-1:0] s_root;

  // Stage 6: divider operands.
  logic              v6_q;
  side_t             sd6_q;
  logic [NUM_W-1:0]  ny6_q, nz6_q;

  // Divider output.
  logic              vc_vld;
  side_t             sdc;
  logic [NUM_W-1:0]  quo_y, quo_z;

  // Stage 7: coordinate four-vector.
  logic              v7_q;
  side_t             sd7_q;
  logic [DATA_W-1:0] q7_q [4];

  // Stage 8: magnitudes and signs for the momentum products.
  logic              v8_q, deg8_q;
  logic [DATA_W-1:0] q8_q [4];
  logic [DATA_W-1:0] qm8_q [4];
  logic [3:0]        qn8_q;
  logic [DATA_W-1:0] mm8_q [3];
  logic [2:0]        mn8_q;

  // Stage 9: partial products of the twelve terms.
  logic              v9_q, deg9_q;
  logic [DATA_W-1:0] q9_q [4];
  logic [DATA_W-1:0] hh9_q [4][3];
  logic [DATA_W-1:0] hl9_q [4][3];
  logic [DATA_W-1:0] lh9_q [4][3];
  logic [DATA_W-1:0] ll9_q [4][3];
  logic              sg9_q [4][3];

  // Stage 10: term magnitudes.
  logic              v10_q, deg10_q;
  logic [DATA_W-1:0] q10_q [4];
  logic [RAD_W-1:0]  tm10_q [4][3];
  logic              sg10_q [4][3];

  // Stage 11: signed terms.
  logic              v11_q, deg11_q;
  logic [DATA_W-1:0] q11_q [4];
  logic [SUM_W-1:0]  t11_q [4][3];

  // Stage 12: result register.
  logic              v12_q, deg12_q;
  logic [DATA_W-1:0] oq_q [4];
  logic [DATA_W-1:0] op_q [4];

  assign en          = !v12_q || res_o.ready;
  assign req_i.ready = en;

  // Valid bits of the registered stages around the arithmetic units.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q  <= 1'b0;
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
      v4_q  <= 1'b0;
      v5_q  <= 1'b0;
      v6_q  <= 1'b0;
      v7_q  <= 1'b0;
      v8_q  <= 1'b0;
      v9_q  <= 1'b0;
      v10_q <= 1'b0;
      v11_q <= 1'b0;
      v12_q <= 1'b0;
    end else if (en) begin
      v0_q  <= req_i.valid;
      v1_q  <= v0_q;
      v2_q  <= v1_q;
      v3_q  <= v2_q;
      v4_q  <= v3_q;
      v5_q  <= va_vld;
      v6_q  <= vb_vld;
      v7_q  <= vc_vld;
      v8_q  <= v7_q;
      v9_q  <= v8_q;
      v10_q <= v9_q;
      v11_q <= v10_q;
      v12_q <= v11_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      bx0_q <= req_i.body_x;
      by0_q <= req_i.body_y;
      bz0_q <= req_i.body_z;
      rx0_q <= req_i.ref_x;
      ry0_q <= req_i.ref_y;
      rz0_q <= req_i.ref_z;
      mx0_q <= req_i.mom_x;
      my0_q <= req_i.mom_y;
      mz0_q <= req_i.mom_z;
    end
  end

  assign dx = sat_sub(bx0_q, rx0_q);
  assign dy = sat_sub(by0_q, ry0_q);
  assign dz = sat_sub(bz0_q, rz0_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      sd1_q.deg  <= (dx == '0) && (dy == '0) && (dz == '0);
      sd1_q.xneg <= dx[DATA_W-1];
      sd1_q.adx  <= mag(dx);
      sd1_q.dy   <= dy;
      sd1_q.dz   <= dz;
      sd1_q.mx   <= mx0_q;
      sd1_q.my   <= my0_q;
      sd1_q.mz   <= mz0_q;
      sd1_q.s    <= '0;
      ay1_q      <= mag(dy);
      az1_q      <= mag(dz);
    end
  end

  // Squares: a*a = hh*2^64 + 2*hl*2^32 + ll with 32-bit halves.
  always_ff @(posedge clk_i) begin
    logic [DATA_W-1:0] op [3];
    if (en) begin
      op[0] = sd1_q.adx;
      op[1] = ay1_q;
      op[2] = az1_q;
      for (int i = 0; i < 3; i++) begin
        hh2_q[i] <= op[i][DATA_W-1:DATA_W/2] * op[i][DATA_W-1:DATA_W/2];
        hl2_q[i] <= op[i][DATA_W-1:DATA_W/2] * op[i][DATA_W/2-1:0];
        ll2_q[i] <= op[i][DATA_W/2-1:0] * op[i][DATA_W/2-1:0];
      end
      sd2_q <= sd1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq3_q[i] <= (RAD_W'(hh2_q[i]) << DATA_W) + (RAD_W'(hl2_q[i]) << (DATA_W/2 + 1))
                    + RAD_W'(ll2_q[i]);
      end
      sd3_q  <= sd2_q;
      sum4_q <= sq3_q[0] + sq3_q[1] + sq3_q[2];
      sd4_q  <= sd3_q;
    end
  end

  ks_isqrt u_root_r (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (v4_q),
    .side_i (sd4_q),
    .rad_i  (sum4_q),
    .vld_o  (va_vld),
    .side_o (sda),
    .root_o (r_root)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      n5_q  <= RAD_W'({1'b0, r_root} + {1'b0, sda.adx}) << (FRAC_BITS - 1);
      sd5_q <= sda;
    end
  end

  ks_isqrt u_root_s (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (v5_q),
    .side_i (sd5_q),
    .rad_i  (n5_q),
    .vld_o  (vb_vld),
    .side_o (sdb),
    .root_o (s_root)
  );

  always_ff @(posedge clk_i) begin
    side_t sd;
    if (en) begin
      sd      = sdb;
      sd.s    = s_root;
      ny6_q   <= NUM_W'(mag(sdb.dy)) << (FRAC_BITS - 1);
      nz6_q   <= NUM_W'(mag(sdb.dz)) << (FRAC_BITS - 1);
      sd6_q   <= sd;
    end
  end

  ks_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .vld_i   (v6_q),
    .side_i  (sd6_q),
    .num_y_i (ny6_q),
    .num_z_i (nz6_q),
    .den_i   (sd6_q.s),
    .vld_o   (vc_vld),
    .side_o  (sdc),
    .quo_y_o (quo_y),
    .quo_z_o (quo_z)
  );

  // Branch on the sign of relative x.
  always_ff @(posedge clk_i) begin
    logic [DATA_W-1:0] qy, qz;
    if (en) begin
      qy = sat_sm(sdc.dy[DATA_W-1], quo_y);
      qz = sat_sm(sdc.dz[DATA_W-1], quo_z);
      if (!sdc.xneg) begin
        q7_q[0] <= sdc.s;
        q7_q[1] <= qy;
        q7_q[2] <= qz;
        q7_q[3] <= '0;
      end else begin
        q7_q[0] <= qy;
        q7_q[1] <= sdc.s;
        q7_q[2] <= '0;
        q7_q[3] <= qz;
      end
      sd7_q <= sdc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        q8_q[i]  <= q7_q[i];
        qm8_q[i] <= mag(q7_q[i]);
        qn8_q[i] <= q7_q[i][DATA_W-1];
      end
      mm8_q[0] <= mag(sd7_q.mx);
      mm8_q[1] <= mag(sd7_q.my);
      mm8_q[2] <= mag(sd7_q.mz);
      mn8_q    <= {sd7_q.mz[DATA_W-1], sd7_q.my[DATA_W-1], sd7_q.mx[DATA_W-1]};
      deg8_q   <= sd7_q.deg;
    end
  end

  always_ff @(posedge clk_i) begin
    logic [DATA_W-1:0] a, b;
    if (en) begin
      for (int j = 0; j < 4; j++) begin
        for (int k = 0; k < 3; k++) begin
          a = qm8_q[QSEL[j][k]];
          b = mm8_q[k];
          hh9_q[j][k] <= a[DATA_W-1:DATA_W/2] * b[DATA_W-1:DATA_W/2];
          hl9_q[j][k] <= a[DATA_W-1:DATA_W/2] * b[DATA_W/2-1:0];
          lh9_q[j][k] <= a[DATA_W/2-1:0] * b[DATA_W-1:DATA_W/2];
          ll9_q[j][k] <= a[DATA_W/2-1:0] * b[DATA_W/2-1:0];
          sg9_q[j][k] <= qn8_q[QSEL[j][k]] ^ mn8_q[k] ^ MINUS[j][k];
        end
      end
      q9_q   <= q8_q;
      deg9_q <= deg8_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int j = 0; j < 4; j++) begin
        for (int k = 0; k < 3; k++) begin
          tm10_q[j][k] <= (RAD_W'(hh9_q[j][k]) << DATA_W)
                          + ((RAD_W'(hl9_q[j][k]) + RAD_W'(lh9_q[j][k])) << (DATA_W/2))
                          + RAD_W'(ll9_q[j][k]);
          sg10_q[j][k] <= sg9_q[j][k];
        end
      end
      q10_q   <= q9_q;
      deg10_q <= deg9_q;
    end
  end

  always_ff @(posedge clk_i) begin
    logic [SUM_W-1:0] ext;
    if (en) begin
      for (int j = 0; j < 4; j++) begin
        for (int k = 0; k < 3; k++) begin
          ext = SUM_W'(tm10_q[j][k]);
          t11_q[j][k] <= sg10_q[j][k] ? (~ext + 1'b1) : ext;
        end
      end
      q11_q   <= q10_q;
      deg11_q <= deg10_q;
    end
  end

  // Exact sum, floor shift by FRAC_BITS-1 (the factor two and the rescale),
  // then saturation.
  always_ff @(posedge clk_i) begin
    logic signed [SUM_W-1:0] sum, sh;
    logic                    fits;
    if (en) begin
      for (int j = 0; j < 4; j++) begin
        sum  = $signed(t11_q[j][0] + t11_q[j][1] + t11_q[j][2]);
        sh   = sum >>> (FRAC_BITS - 1);
        fits = (&sh[SUM_W-1:DATA_W-1]) | ~(|sh[SUM_W-1:DATA_W-1]);
        if (deg11_q) begin
          op_q[j] <= '0;
          oq_q[j] <= '0;
        end else begin
          op_q[j] <= fits ? sh[DATA_W-1:0] : (sh[SUM_W-1] ? SMIN : SMAX);
          oq_q[j] <= q11_q[j];
        end
      end
      deg12_q <= deg11_q;
    end
  end

  assign res_o.valid      = v12_q;
  assign res_o.ks_q1      = oq_q[0];
  assign res_o.ks_q2      = oq_q[1];
  assign res_o.ks_q3      = oq_q[2];
  assign res_o.ks_q4      = oq_q[3];
  assign res_o.ks_p1      = op_q[0];
  assign res_o.ks_p2      = op_q[1];
  assign res_o.ks_p3      = op_q[2];
  assign res_o.ks_p4      = op_q[3];
  assign res_o.degenerate = deg12_q;

endmodule

`default_nettype wire
